// ===== hw/rtl/fbfa_pkg.sv =====
// fbfa_pkg: constants, codes and types shared by the fixed block allocator
// used by the channel interfaces, the divider and the top level
`default_nettype none

package fbfa_pkg;

  // ring capacity, a power of two so that pointers wrap by themselves
  localparam int unsigned BLOCKS       = 1024;
  localparam int unsigned ADDRESS_BITS = 32;

  localparam int unsigned PTR_W      = $clog2(BLOCKS);
  localparam int unsigned LEVEL_W    = PTR_W + 1;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = PTR_W + SIZE_W;

  localparam int unsigned RST_BASE  = 0;
  localparam int unsigned RST_SIZE  = 64;
  localparam int unsigned RST_COUNT = (1024 > BLOCKS) ? BLOCKS : 1024;
  localparam int unsigned RST_WPTR  = RST_COUNT % BLOCKS;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FREED     = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_DIV,
    S_FREE_UPD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                    start;
    logic [ADDRESS_BITS-1:0] dividend;
    logic [SIZE_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [ADDRESS_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fbfa_if.sv =====
// fbfa channel interfaces: request, response and configuration write
// depends on fbfa_pkg for field widths
`default_nettype none

interface fbfa_req_if;
  logic                              valid;
  logic                              ready;
  logic [0:0]                        command;
  logic [fbfa_pkg::ADDRESS_BITS-1:0] free_address;

  modport source (output valid, command, free_address, input ready);
  modport sink (input valid, command, free_address, output ready);
endinterface

interface fbfa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fbfa_pkg::ADDRESS_BITS-1:0] block_address;
  logic [fbfa_pkg::IDX_W-1:0]        block_index;
  logic [fbfa_pkg::STATUS_W-1:0]     status;

  modport source (output valid, block_address, block_index, status, input ready);
  modport sink (input valid, block_address, block_index, status, output ready);
endinterface

interface fbfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbfa_pkg::CFG_IDX_W-1:0]  index;
  logic [fbfa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fbfa_divider.sv =====
// fbfa_divider: restoring divider, one quotient bit per cycle
// depends on fbfa_pkg for widths and the request and response structs
`default_nettype none

module fbfa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbfa_pkg::div_req_t req_i,
  output fbfa_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW    = fbfa_pkg::ADDRESS_BITS;
  localparam int unsigned SW    = fbfa_pkg::SIZE_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [SW-1:0]    dvs_q, dvs_d;

  logic [SW:0]      trial;
  logic [SW:0]      diff;
  logic             fits;

  // partial remainder stays below the divisor, so the shifted value fits SW+1 bits
  assign trial = {rem_q, quo_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[SW-1:0] : trial[SW-1:0];
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // a zero divisor gives an all-ones quotient
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator_unit.sv =====
// fixed_block_free_list_allocator_unit: fixed-size block pool with a ring of free indices
// depends on fbfa_pkg, the channel interfaces in fbfa_if and fbfa_divider
`default_nettype none

// One word in, one word out. An allocate pops the oldest free index from a
// 1024-entry ring memory (registered read) and answers base + index * size;
// the ring is read at acceptance, then the multiply (S_ALLOC_MUL), the add
// (S_ALLOC_ADD) and the hand-over (S_DONE) follow in that order. A free
// subtracts the base and divides by the block size in a 32-step restoring
// divider, one quotient bit a cycle, then updates the ring (S_FREE_UPD) before
// the hand-over; that divider sets the rate. An allocate on an empty pool goes
// straight to the hand-over. The next word is taken the cycle after the result
// is loaded; the load waits while the output register holds an untaken result.
// One word is worked on at a time, but a new word is taken while the previous
// result still waits in the output register.
// Writing the block count refills the ring at once: no clearing pass runs, as a
// count of pushes since the refill tells which slots still hold their own index.
// Configuration must be written only while the block is idle; nothing enforces it.
module fixed_block_free_list_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbfa_cfg_if.sink   cfg_i,
  fbfa_req_if.sink   req_i,
  fbfa_rsp_if.source rsp_o
);

  localparam int unsigned AW = fbfa_pkg::ADDRESS_BITS;
  localparam int unsigned PW = fbfa_pkg::PTR_W;
  localparam int unsigned LW = fbfa_pkg::LEVEL_W;

  // configuration
  logic [AW-1:0]                base_q, base_d;
  logic [fbfa_pkg::SIZE_W-1:0]  size_q, size_d;
  logic [fbfa_pkg::COUNT_W-1:0] count_q, count_d;

  // ring bookkeeping
  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] wp0_q, wp0_d;   // write pointer at the last refill
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] push_q, push_d; // pushes since refill, saturating at capacity

  fbfa_pkg::state_e state_q, state_d;

  // per-word datapath
  logic [fbfa_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [AW-1:0]                 res_addr_q, res_addr_d;
  logic [fbfa_pkg::IDX_W-1:0]    res_idx_q, res_idx_d;
  logic [fbfa_pkg::STATUS_W-1:0] res_stat_q, res_stat_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [AW-1:0]                 out_addr_q, out_addr_d;
  logic [fbfa_pkg::IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [fbfa_pkg::STATUS_W-1:0] out_stat_q, out_stat_d;

  // ring memory
  logic [PW-1:0] ring_mem [fbfa_pkg::BLOCKS];
  logic [PW-1:0] rd_data_q;

  // control strobes
  logic req_ready, mem_re, mem_we, div_start, out_load;
  logic req_fire, cfg_fire, is_alloc;
  logic slot_pushed, in_range, ring_full;
  logic [PW-1:0] pop_idx;
  logic [fbfa_pkg::COUNT_W-1:0] count_sat;

  fbfa_pkg::div_req_t div_req;
  fbfa_pkg::div_rsp_t div_rsp;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = req_ready;
  assign req_fire    = req_i.valid && req_ready;
  assign is_alloc    = req_i.command == fbfa_pkg::CMD_ALLOC;

  assign count_sat = (32'(cfg_i.data[fbfa_pkg::COUNT_W-1:0]) > fbfa_pkg::BLOCKS)
                   ? fbfa_pkg::COUNT_W'(fbfa_pkg::BLOCKS)
                   : cfg_i.data[fbfa_pkg::COUNT_W-1:0];

  // a slot not yet rewritten since the refill still holds its own index
  assign slot_pushed = {1'b0, PW'(rp_q - wp0_q)} < push_q;
  assign pop_idx     = slot_pushed ? rd_data_q : rp_q;

  assign in_range  = div_rsp.quotient < AW'(count_q);
  assign ring_full = level_q >= LW'(fbfa_pkg::BLOCKS);

  assign div_req.start    = div_start;
  assign div_req.dividend = req_i.free_address - base_q;
  assign div_req.divisor  = size_q;

  fbfa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbfa_pkg::S_IDLE: begin
        if (req_fire) begin
          if (!is_alloc) begin
            state_d = fbfa_pkg::S_DIV;
          end else if (level_q == '0) begin
            state_d = fbfa_pkg::S_DONE;
          end else begin
            state_d = fbfa_pkg::S_ALLOC_MUL;
          end
        end
      end
      fbfa_pkg::S_ALLOC_MUL: state_d = fbfa_pkg::S_ALLOC_ADD;
      fbfa_pkg::S_ALLOC_ADD: state_d = fbfa_pkg::S_DONE;
      fbfa_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = fbfa_pkg::S_FREE_UPD;
        end
      end
      fbfa_pkg::S_FREE_UPD: state_d = fbfa_pkg::S_DONE;
      fbfa_pkg::S_DONE: begin
        if (out_load) begin
          state_d = fbfa_pkg::S_IDLE;
        end
      end
      default: state_d = fbfa_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      fbfa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        mem_re    = req_i.valid && is_alloc;
        div_start = req_i.valid && !is_alloc;
      end
      fbfa_pkg::S_FREE_UPD: mem_we = in_range && !ring_full;
      fbfa_pkg::S_DONE:     out_load = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  // datapath and bookkeeping
  always_comb begin
    base_d     = base_q;
    size_d     = size_q;
    count_d    = count_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    wp0_d      = wp0_q;
    level_d    = level_q;
    push_d     = push_q;
    prod_d     = prod_q;
    res_addr_d = res_addr_q;
    res_idx_d  = res_idx_q;
    res_stat_d = res_stat_q;

    if (cfg_fire) begin
      unique case (cfg_i.index)
        fbfa_pkg::REG_BASE: base_d = cfg_i.data[AW-1:0];
        fbfa_pkg::REG_SIZE: size_d = cfg_i.data[fbfa_pkg::SIZE_W-1:0];
        fbfa_pkg::REG_COUNT: begin
          count_d = count_sat;
          rp_d    = '0;
          wp_d    = count_sat[PW-1:0];
          wp0_d   = count_sat[PW-1:0];
          level_d = LW'(count_sat);
          push_d  = '0;
        end
        default: ;
      endcase
    end

    if (state_q == fbfa_pkg::S_IDLE && req_fire && is_alloc && level_q == '0) begin
      res_addr_d = '0;
      res_idx_d  = '0;
      res_stat_d = fbfa_pkg::STAT_EMPTY;
    end

    if (state_q == fbfa_pkg::S_ALLOC_MUL) begin
      prod_d    = pop_idx * size_q;
      res_idx_d = fbfa_pkg::IDX_W'(pop_idx);
      rp_d      = rp_q + PW'(1);
      level_d   = level_q - LW'(1);
    end

    if (state_q == fbfa_pkg::S_ALLOC_ADD) begin
      res_addr_d = base_q + AW'(prod_q);
      res_stat_d = fbfa_pkg::STAT_ALLOCATED;
    end

    if (state_q == fbfa_pkg::S_FREE_UPD) begin
      res_addr_d = '0;
      if (!in_range) begin
        res_idx_d  = '0;
        res_stat_d = fbfa_pkg::STAT_RANGE;
      end else if (ring_full) begin
        res_idx_d  = '0;
        res_stat_d = fbfa_pkg::STAT_FULL;
      end else begin
        res_idx_d  = fbfa_pkg::IDX_W'(div_rsp.quotient);
        res_stat_d = fbfa_pkg::STAT_FREED;
      end
    end

    if (mem_we) begin
      wp_d    = wp_q + PW'(1);
      level_d = level_q + LW'(1);
      if (push_q != LW'(fbfa_pkg::BLOCKS)) begin
        push_d = push_q + LW'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_idx_d   = out_idx_q;
    out_stat_d  = out_stat_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_addr_d  = res_addr_q;
      out_idx_d   = res_idx_q;
      out_stat_d  = res_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbfa_pkg::S_IDLE;
      base_q      <= AW'(fbfa_pkg::RST_BASE);
      size_q      <= fbfa_pkg::SIZE_W'(fbfa_pkg::RST_SIZE);
      count_q     <= fbfa_pkg::COUNT_W'(fbfa_pkg::RST_COUNT);
      rp_q        <= '0;
      wp_q        <= PW'(fbfa_pkg::RST_WPTR);
      wp0_q       <= PW'(fbfa_pkg::RST_WPTR);
      level_q     <= LW'(fbfa_pkg::RST_COUNT);
      push_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      size_q      <= size_d;
      count_q     <= count_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      wp0_q       <= wp0_d;
      level_q     <= level_d;
      push_q      <= push_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    res_addr_q <= res_addr_d;
    res_idx_q  <= res_idx_d;
    res_stat_q <= res_stat_d;
    out_addr_q <= out_addr_d;
    out_idx_q  <= out_idx_d;
    out_stat_q <= out_stat_d;
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= div_rsp.quotient[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= ring_mem[rp_q];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.block_index   = out_idx_q;
  assign rsp_o.status        = out_stat_q;

  // occupancy always matches the pointer distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(wp_q - rp_q) == level_q[PW-1:0])
    else $error("ring level disagrees with pointers");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(fbfa_pkg::BLOCKS) && push_q <= LW'(fbfa_pkg::BLOCKS))
    else $error("ring level or push count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !ring_full && in_range)
    else $error("ring written while full or out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == fbfa_pkg::S_DIV)
    else $error("divider finished outside a free");

endmodule

`default_nettype wire

// ===== verif/fixed_block_free_list_allocator_unit_tb.sv =====
// testbench for fixed_block_free_list_allocator_unit: directed and random allocate/free traffic
// with a self-contained prediction of the free ring; depends on fbfa_pkg and the fbfa_if channels
`default_nettype none

module fixed_block_free_list_allocator_unit_tb;
  import fbfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] block_address;
    logic [IDX_W-1:0]        block_index;
    status_e                 status;
  } pool_answer_t;

  logic clk;
  logic rst_ni;

  fbfa_cfg_if cfg_if ();
  fbfa_req_if req_if ();
  fbfa_rsp_if rsp_if ();

  fixed_block_free_list_allocator_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted pool state
  logic [ADDRESS_BITS-1:0] pool_base;
  logic [SIZE_W-1:0]       pool_size;
  int unsigned             pool_count;
  logic [PTR_W-1:0]        free_slots [BLOCKS];
  logic [PTR_W-1:0]        take_ptr;
  logic [PTR_W-1:0]        put_ptr;
  int unsigned             free_total;

  pool_answer_t            awaited_answers[$];
  logic [ADDRESS_BITS-1:0] held_blocks[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          calm = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned draw_pause();
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void refill_ring();
    for (int i = 0; i < BLOCKS; i++) begin
      free_slots[i] = PTR_W'(i);
    end
    take_ptr = '0;
    put_ptr = PTR_W'(pool_count % BLOCKS);
    free_total = pool_count;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned cnt;
    case (idx)
      REG_BASE: begin
        pool_base = data;
      end
      REG_SIZE: begin
        pool_size = data[SIZE_W-1:0];
      end
      REG_COUNT: begin
        cnt = data[COUNT_W-1:0];
        pool_count = (cnt > BLOCKS) ? BLOCKS : cnt;
        refill_ring();
      end
      default: ;
    endcase
  endfunction

  function automatic pool_answer_t serve_request(cmd_e cmd, logic [ADDRESS_BITS-1:0] addr);
    pool_answer_t      ans;
    logic [ADDRESS_BITS-1:0] offset;
    longint unsigned   quot;
    ans = '{block_address: '0, block_index: '0, status: STAT_ALLOCATED};
    if (cmd == CMD_ALLOC) begin
      if (free_total == 0) begin
        ans.status = STAT_EMPTY;
      end else begin
        ans.block_index = free_slots[take_ptr];
        take_ptr = take_ptr + 1'b1;
        free_total--;
        ans.block_address = pool_base + 32'(ans.block_index) * 32'(pool_size);
        held_blocks.push_back(ans.block_address);
      end
    end else begin
      offset = addr - pool_base;
      // a zero size makes the divider answer all ones
      if (pool_size == '0) begin
        quot = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        quot = longint'(offset) / longint'(pool_size);
      end
      if (quot >= pool_count) begin
        ans.status = STAT_RANGE;
      end else if (free_total >= BLOCKS) begin
        ans.status = STAT_FULL;
      end else begin
        free_slots[put_ptr] = quot[PTR_W-1:0];
        put_ptr = put_ptr + 1'b1;
        free_total++;
        ans.block_index = quot[IDX_W-1:0];
        ans.status = STAT_FREED;
      end
    end
    return ans;
  endfunction

  // response side: random stall after each word, checked against the oldest prediction
  always @(negedge clk) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pool_answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      hold_left = draw_pause();
      if (awaited_answers.size() == 0) begin
        $display("%0t unexpected word: block_address %h block_index %0d status %0d", $time,
                 rsp_if.block_address, rsp_if.block_index, rsp_if.status);
        error_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (rsp_if.block_address !== want.block_address) begin
          $display("%0t block_address: expected %h, got %h", $time,
                   want.block_address, rsp_if.block_address);
          error_count++;
        end
        if (rsp_if.block_index !== want.block_index) begin
          $display("%0t block_index: expected %0d, got %0d", $time,
                   want.block_index, rsp_if.block_index);
          error_count++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status, rsp_if.status);
          error_count++;
        end
      end
    end
  end

  // called and left at a falling edge; valid stays high so that back-to-back words need no gap
  task automatic send_request(cmd_e cmd, logic [ADDRESS_BITS-1:0] addr);
    int unsigned gap;
    gap = draw_pause();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.command = cmd;
    req_if.free_address = addr;
    do @(posedge clk); while (!req_if.ready);
    awaited_answers.push_back(serve_request(cmd, addr));
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_if.valid = 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_setting(idx, data);
    held_blocks.delete();
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [ADDRESS_BITS-1:0] address_of(int unsigned idx, int unsigned offs);
    return pool_base + 32'(idx) * 32'(pool_size) + 32'(offs);
  endfunction

  task automatic test_after_reset();
    // the reset pool is full, so a valid free is dropped
    send_request(CMD_FREE, 32'h0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'd127);
    send_request(CMD_FREE, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    write_register(REG_BASE, 32'hFFFF_FFF0);
    write_register(REG_SIZE, 32'h0000_FFFF);
    write_register(REG_COUNT, 32'd3);
    // the last allocate finds the pool empty; the second address wraps
    repeat (4) send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, address_of(2, 16'hFFFE));
    send_request(CMD_FREE, address_of(3, 0));
    send_request(CMD_FREE, pool_base - 1);
    // double free is accepted while there is room
    send_request(CMD_FREE, address_of(2, 0));
  endtask

  task automatic test_degenerate_settings();
    write_register(REG_SIZE, 32'd0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, pool_base);
    write_register(REG_COUNT, 32'd0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, pool_base);
    write_register(REG_SPARE, 32'd5);
    // count above capacity is saturated
    write_register(REG_COUNT, 32'd2047);
    write_register(REG_SIZE, 32'd1);
    write_register(REG_BASE, 32'd0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'd1023);
    send_request(CMD_FREE, 32'd1024);
  endtask

  task automatic run_random_phase(logic [31:0] base, logic [31:0] size, logic [31:0] count,
                                  int unsigned n);
    int unsigned sel;
    int unsigned k;
    int unsigned idx;
    int unsigned offs;
    logic [ADDRESS_BITS-1:0] addr;
    write_register(REG_BASE, base);
    write_register(REG_SIZE, size);
    write_register(REG_COUNT, count);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 4) && (i < n / 4 + 20);
      if (i == n / 2) begin
        drain_results();
      end
      sel = $urandom_range(0, 99);
      offs = (pool_size == '0) ? 0 : $urandom_range(0, pool_size - 1);
      if (sel < 50) begin
        send_request(CMD_ALLOC, $urandom);
      end else if (sel < 80 && held_blocks.size() > 0) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        addr = held_blocks[k] + 32'(offs);
        held_blocks.delete(k);
        send_request(CMD_FREE, addr);
      end else if (sel < 90 && pool_count > 0) begin
        idx = $urandom_range(0, pool_count - 1);
        send_request(CMD_FREE, address_of(idx, offs));
      end else if (sel < 95) begin
        idx = pool_count + $urandom_range(0, 10);
        send_request(CMD_FREE, address_of(idx, offs));
      end else begin
        send_request(CMD_FREE, $urandom);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    // full ring at the start, so double frees meet a full ring
    run_random_phase($urandom, 32'd64, 32'd1024, 100);
    // a few blocks only: the pool runs empty often
    run_random_phase($urandom, $urandom_range(1, 65535), $urandom_range(1, 8), 100);
    // largest size near the top of the address space wraps the addresses
    run_random_phase(32'hFFFF_0000 | $urandom_range(0, 65535), 32'd65535,
                     $urandom_range(1, 1024), 100);
    run_random_phase($urandom, 32'd1, $urandom_range(1025, 2047), 100);
    run_random_phase($urandom, $urandom_range(1, 65535), $urandom_range(16, 64), 100);
    run_random_phase($urandom, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 300),
                     $urandom_range(1, 1024), 100);
  endtask

  initial begin
    clk = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_ALLOC;
    req_if.free_address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_BASE;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    pool_base = ADDRESS_BITS'(RST_BASE);
    pool_size = SIZE_W'(RST_SIZE);
    pool_count = RST_COUNT;
    refill_ring();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_after_reset();
    test_register_extremes();
    test_degenerate_settings();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/fbfa_pkg.sv
hw/rtl/fbfa_if.sv
hw/rtl/fbfa_divider.sv
hw/rtl/fixed_block_free_list_allocator_unit.sv
verif/fixed_block_free_list_allocator_unit_tb.sv
